### hw/rtl/mrm_pkg.sv
// Shared widths, defaults, register codes and control types for the ROI mean block.
package mrm_pkg;

  localparam int PIXEL_W    = 16;
  localparam int MASK_W     = 8;
  localparam int INDEX_W    = 3;
  localparam int MEAN_W     = 24;
  localparam int MASK_LANES = 8;
  localparam int REGIONS_W  = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int REGION_COUNT_DEF    = 8;
  localparam int MAX_PIXELS_LOG2_DEF = 20;
  localparam int FRACTION_BITS_DEF   = 8;

  localparam logic [REGIONS_W-1:0] REGIONS_RESET = 4'd8;
  localparam logic                 WIDE_RESET    = 1'b1;
  localparam logic [MEAN_W-1:0]    MEAN_MAX      = {MEAN_W{1'b1}};

  typedef enum logic {
    CFG_REGIONS = 1'b0,
    CFG_WIDE    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               acc;
    logic               clear;
    logic               div_start;
    logic               load_out;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

### hw/rtl/mrm_stream_if.sv
// Pixel input and region result stream interfaces.
interface mrm_in_if;
  logic                         valid;
  logic                         ready;
  logic [mrm_pkg::PIXEL_W-1:0]  pixel_value;
  logic [mrm_pkg::MASK_W-1:0]   region_mask_bits;
  logic                         last_pixel;

  modport source (output valid, output pixel_value, output region_mask_bits,
                  output last_pixel, input ready);
  modport sink (input valid, input pixel_value, input region_mask_bits,
                input last_pixel, output ready);
endinterface

interface mrm_out_if;
  logic                         valid;
  logic                         ready;
  logic [mrm_pkg::INDEX_W-1:0]  region_index;
  logic [mrm_pkg::MEAN_W-1:0]   mean_value;
  logic                         region_empty;
  logic                         last_region;

  modport source (output valid, output region_index, output mean_value,
                  output region_empty, output last_region, input ready);
  modport sink (input valid, input region_index, input mean_value,
                input region_empty, input last_region, output ready);
endinterface

### hw/rtl/mrm_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module mrm_divider #(
  parameter int DIVIDEND_W = 44,
  parameter int DIVISOR_W  = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]     step_q, step_d;
  logic                  done_q, done_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  qbit;

  always_comb begin
    trial  = {rem_q, dvd_q[DIVIDEND_W-1]};
    diff   = trial - {1'b0, dvs_q};
    qbit   = (trial >= {1'b0, dvs_q});
    step_d = step_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      step_d = STEP_W'(DIVIDEND_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      done_d = (step_q == STEP_W'(1));
      dvd_d  = {dvd_q[DIVIDEND_W-2:0], qbit};
      rem_d  = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

### hw/rtl/mrm_datapath.sv
// Per-region accumulators, mean divider and result register.
module mrm_datapath #(
  parameter int REGION_COUNT    = mrm_pkg::REGION_COUNT_DEF,
  parameter int MAX_PIXELS_LOG2 = mrm_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int FRACTION_BITS   = mrm_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mrm_pkg::cmd_t                  cmd_i,
  output mrm_pkg::status_t               status_o,
  input  logic [mrm_pkg::REGIONS_W-1:0]  active_i,
  input  logic                           wide_i,
  input  logic [mrm_pkg::PIXEL_W-1:0]    pixel_i,
  input  logic [mrm_pkg::MASK_W-1:0]     mask_i,
  output logic [mrm_pkg::INDEX_W-1:0]    region_index_o,
  output logic [mrm_pkg::MEAN_W-1:0]     mean_value_o,
  output logic                           region_empty_o,
  output logic                           last_region_o
);

  localparam int LANES = (REGION_COUNT < mrm_pkg::MASK_LANES) ? REGION_COUNT
                                                              : mrm_pkg::MASK_LANES;
  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SUM_W = mrm_pkg::PIXEL_W + MAX_PIXELS_LOG2;
  localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
  localparam int DVD_W = SUM_W + FRACTION_BITS;
  localparam int QX_W  = (DVD_W > mrm_pkg::MEAN_W) ? DVD_W : mrm_pkg::MEAN_W + 1;

  logic [SUM_W-1:0] sum_q [LANES];
  logic [CNT_W-1:0] cnt_q [LANES];

  logic [mrm_pkg::PIXEL_W-1:0] pix_eff;
  logic [SUM_W-1:0]            sum_sel;
  logic [CNT_W-1:0]            cnt_sel;
  logic [DVD_W-1:0]            quotient;
  logic [QX_W-1:0]             quot_x;
  logic [mrm_pkg::MEAN_W-1:0]  mean_sat;
  logic                        div_done;

  logic                        empty_q;
  logic [mrm_pkg::INDEX_W-1:0] cur_idx_q;
  logic [mrm_pkg::INDEX_W-1:0] out_idx_q;
  logic [mrm_pkg::MEAN_W-1:0]  out_mean_q;
  logic                        out_empty_q;
  logic                        out_last_q;

  assign pix_eff = wide_i ? pixel_i : {8'd0, pixel_i[7:0]};
  assign sum_sel = sum_q[cmd_i.idx[IDX_W-1:0]];
  assign cnt_sel = cnt_q[cmd_i.idx[IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < LANES; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.acc) begin
      for (int i = 0; i < LANES; i++) begin
        if (mask_i[i] && (mrm_pkg::REGIONS_W'(i) < active_i)
            && !cnt_q[i][MAX_PIXELS_LOG2]) begin
          sum_q[i] <= sum_q[i] + SUM_W'(pix_eff);
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
    end
  end

  mrm_divider #(
    .DIVIDEND_W (DVD_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (DVD_W'(sum_sel) << FRACTION_BITS),
    .divisor_i  (cnt_sel),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign quot_x   = QX_W'(quotient);
  assign mean_sat = (|quot_x[QX_W-1:mrm_pkg::MEAN_W]) ? mrm_pkg::MEAN_MAX
                                                       : quot_x[mrm_pkg::MEAN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      empty_q   <= (cnt_sel == '0);
      cur_idx_q <= cmd_i.idx;
    end
    if (cmd_i.load_out) begin
      out_idx_q   <= cur_idx_q;
      out_mean_q  <= empty_q ? '0 : mean_sat;
      out_empty_q <= empty_q;
      out_last_q  <= cmd_i.last;
    end
  end

  assign status_o.div_done = div_done;
  assign region_index_o    = out_idx_q;
  assign mean_value_o      = out_mean_q;
  assign region_empty_o    = out_empty_q;
  assign last_region_o     = out_last_q;

endmodule

### hw/rtl/mrm_ctrl.sv
// Controller: pixel intake, per-region report sequencing and result handshake.
module mrm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          last_pixel_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [mrm_pkg::REGIONS_W-1:0] active_i,
  input  mrm_pkg::status_t              status_i,
  output mrm_pkg::cmd_t                 cmd_o
);

  typedef enum logic [1:0] {
    ST_ACC,
    ST_START,
    ST_DIV,
    ST_WAIT
  } state_e;

  state_e                      state_q, state_d;
  logic [mrm_pkg::INDEX_W-1:0] idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  logic                        final_region;

  assign final_region = ((mrm_pkg::REGIONS_W'(idx_q) + 1'b1) == active_i);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_ACC: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (last_pixel_i) begin
            if (active_i == '0) begin
              cmd_o.clear = 1'b1;
            end else begin
              idx_d   = '0;
              state_d = ST_START;
            end
          end
        end
      end
      ST_START: begin
        // last pixel is in the accumulators by now
        cmd_o.idx       = idx_q;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          cmd_o.last     = final_region;
          out_valid_d    = 1'b1;
          if (final_region) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_ACC;
          end else begin
            idx_d           = idx_q + 1'b1;
            cmd_o.idx       = idx_q + 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_ACC);
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/masked_roi_mean_intensity.sv
// Top level: masked region-of-interest mean with APB configuration registers.
// Pixels: one transfer per cycle while the input is ready, accumulated in every active region
// whose mask bit is set and whose count is not full. Last pixel: each active region's mean is
// then computed in turn in the bit-serial divider. Input stalls while the regions are reported,
// also under output back-pressure; the last result may still wait after input resumes.
// Reset: asynchronous, active low; clears accumulators, sets 8 regions and wide pixels.
module masked_roi_mean_intensity #(
  parameter int REGION_COUNT    = mrm_pkg::REGION_COUNT_DEF,
  parameter int MAX_PIXELS_LOG2 = mrm_pkg::MAX_PIXELS_LOG2_DEF,
  parameter int FRACTION_BITS   = mrm_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mrm_in_if.sink                          in_i,
  mrm_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mrm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mrm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mrm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int LANES = (REGION_COUNT < mrm_pkg::MASK_LANES) ? REGION_COUNT
                                                              : mrm_pkg::MASK_LANES;

  logic [mrm_pkg::REGIONS_W-1:0] regions_q;
  logic                          wide_q;
  logic [mrm_pkg::REGIONS_W-1:0] active;
  logic                          cfg_write;
  mrm_pkg::cmd_t                 cmd;
  mrm_pkg::status_t              status;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regions_q <= mrm_pkg::REGIONS_RESET;
      wide_q    <= mrm_pkg::WIDE_RESET;
    end else if (cfg_write) begin
      unique case (mrm_pkg::cfg_reg_e'(paddr[2]))
        mrm_pkg::CFG_REGIONS: regions_q <= pwdata[mrm_pkg::REGIONS_W-1:0];
        mrm_pkg::CFG_WIDE:    wide_q    <= pwdata[0];
        default:              regions_q <= regions_q;
      endcase
    end
  end

  always_comb begin
    unique case (mrm_pkg::cfg_reg_e'(paddr[2]))
      mrm_pkg::CFG_REGIONS: prdata = mrm_pkg::APB_DATA_W'(regions_q);
      mrm_pkg::CFG_WIDE:    prdata = mrm_pkg::APB_DATA_W'(wide_q);
      default:              prdata = '0;
    endcase
  end

  assign active = (regions_q > mrm_pkg::REGIONS_W'(LANES)) ? mrm_pkg::REGIONS_W'(LANES)
                                                           : regions_q;

  mrm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .last_pixel_i (in_i.last_pixel),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .active_i     (active),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  mrm_datapath #(
    .REGION_COUNT    (REGION_COUNT),
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .active_i       (active),
    .wide_i         (wide_q),
    .pixel_i        (in_i.pixel_value),
    .mask_i         (in_i.region_mask_bits),
    .region_index_o (out_o.region_index),
    .mean_value_o   (out_o.mean_value),
    .region_empty_o (out_o.region_empty),
    .last_region_o  (out_o.last_region)
  );

endmodule

### test/tb_top.sv
// Testbench for masked_roi_mean_intensity: directed and random frames against a predictor.
module tb_top;

  localparam int REGIONS       = mrm_pkg::REGION_COUNT_DEF;
  localparam int COUNT_LIMIT   = 1 << mrm_pkg::MAX_PIXELS_LOG2_DEF;
  localparam int SUM_W         = mrm_pkg::PIXEL_W + mrm_pkg::MAX_PIXELS_LOG2_DEF;
  localparam int COUNT_W       = mrm_pkg::MAX_PIXELS_LOG2_DEF + 1;
  localparam int SCALED_W      = SUM_W + mrm_pkg::FRACTION_BITS_DEF;
  localparam int DIV_CYCLES    = mrm_pkg::PIXEL_W + mrm_pkg::MAX_PIXELS_LOG2_DEF
                                 + mrm_pkg::FRACTION_BITS_DEF + 2;
  localparam int REPORT_CYCLES = REGIONS * DIV_CYCLES + 16;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic [mrm_pkg::INDEX_W-1:0] region;
    logic [mrm_pkg::MEAN_W-1:0]  mean;
    logic                        empty;
    logic                        last;
  } roi_mean_t;

  typedef struct packed {
    logic [mrm_pkg::REGIONS_W-1:0] regions;
    logic                          wide;
    logic [mrm_pkg::PIXEL_W-1:0]   pixel;
    logic [mrm_pkg::MASK_W-1:0]    mask;
    logic                          last;
    logic                          fixed;
    logic [mrm_pkg::MEAN_W-1:0]    mean;
    logic                          empty;
  } pixel_row_t;

  typedef struct {
    logic [mrm_pkg::REGIONS_W-1:0] regions;
    logic                          wide;
    int                            idle_pct;
    int                            stall_pct;
    int                            items;
  } phase_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [mrm_pkg::APB_ADDR_W-1:0] paddr;
  logic [mrm_pkg::APB_DATA_W-1:0] pwdata;
  logic [mrm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  mrm_in_if  pix_if ();
  mrm_out_if mean_if ();

  masked_roi_mean_intensity u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pix_if),
    .out_o   (mean_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // fixed = 1: every active region expects the typed mean and empty flag
  pixel_row_t directed_rows [23] = '{
    '{4'd8,  1'b1, 16'h1234, 8'h00, 1'b1, 1'b1, 24'h000000, 1'b1},
    '{4'd8,  1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 24'hFFFF00, 1'b0},
    '{4'd8,  1'b1, 16'h0000, 8'hFF, 1'b1, 1'b1, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'h0001, 8'hFF, 1'b1, 1'b1, 24'h800000, 1'b0},
    '{4'd8,  1'b1, 16'h0064, 8'h01, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'h00C8, 8'h03, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'h0007, 8'h80, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'hAAAA, 8'h55, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'h5555, 8'hAA, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'h0003, 8'h0F, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd0,  1'b1, 16'h1234, 8'hFF, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b1, 16'h0010, 8'hFF, 1'b1, 1'b1, 24'h001000, 1'b0},
    '{4'd15, 1'b1, 16'h0200, 8'hFF, 1'b1, 1'b1, 24'h020000, 1'b0},
    '{4'd9,  1'b1, 16'h0005, 8'h80, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{4'd1,  1'b1, 16'h0300, 8'hFE, 1'b1, 1'b1, 24'h000000, 1'b1},
    '{4'd1,  1'b1, 16'h0300, 8'h01, 1'b1, 1'b1, 24'h030000, 1'b0},
    '{4'd8,  1'b0, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 24'h00FF00, 1'b0},
    '{4'd8,  1'b0, 16'hAB12, 8'h0F, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd8,  1'b0, 16'h0034, 8'hFF, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{4'd3,  1'b0, 16'h8001, 8'h05, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{4'd3,  1'b0, 16'h7FFE, 8'h07, 1'b1, 1'b0, 24'h000000, 1'b0}
  };

  phase_t phases [7] = '{
    '{4'd8,  1'b1, 0,  0,  80},
    '{4'd5,  1'b0, 66, 0,  75},
    '{4'd1,  1'b1, 0,  66, 75},
    '{4'd15, 1'b0, 34, 34, 75},
    '{4'd0,  1'b1, 0,  0,  20},
    '{4'd3,  1'b1, 34, 34, 60},
    '{4'd8,  1'b1, 0,  66, 50}
  };

  logic [SUM_W-1:0]              roi_sum   [REGIONS];
  logic [COUNT_W-1:0]            roi_count [REGIONS];
  logic [mrm_pkg::REGIONS_W-1:0] regions_cfg;
  logic                          wide_cfg;
  roi_mean_t                     pending_means [$];
  int                            mismatches = 0;
  int                            send_idle_pct = 0;
  int                            stall_pct = 0;
  int                            idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int active_regions();
    int n;
    n = int'(regions_cfg);
    if (n > REGIONS) n = REGIONS;
    if (n > mrm_pkg::MASK_LANES) n = mrm_pkg::MASK_LANES;
    return n;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches < 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    mismatches++;
  endfunction

  // Accumulate one pixel; on the last pixel queue one mean per active region and clear.
  function automatic void accumulate_pixel(logic [mrm_pkg::PIXEL_W-1:0] pixel,
                                           logic [mrm_pkg::MASK_W-1:0] mask,
                                           logic last, logic fixed,
                                           logic [mrm_pkg::MEAN_W-1:0] fixed_mean,
                                           logic fixed_empty);
    int                          n;
    logic [mrm_pkg::PIXEL_W-1:0] pix;
    logic [SCALED_W-1:0]         quot;
    roi_mean_t                   res;
    n = active_regions();
    pix = wide_cfg ? pixel : {{(mrm_pkg::PIXEL_W-8){1'b0}}, pixel[7:0]};
    for (int r = 0; r < n; r++) begin
      if (mask[r] && roi_count[r] < COUNT_W'(COUNT_LIMIT)) begin
        roi_sum[r]   = roi_sum[r] + SUM_W'(pix);
        roi_count[r] = roi_count[r] + 1'b1;
      end
    end
    if (!last) return;
    for (int r = 0; r < n; r++) begin
      res.region = mrm_pkg::INDEX_W'(r);
      res.last   = (r == n - 1);
      if (fixed) begin
        res.mean  = fixed_mean;
        res.empty = fixed_empty;
      end else if (roi_count[r] == '0) begin
        res.mean  = '0;
        res.empty = 1'b1;
      end else begin
        quot      = (SCALED_W'(roi_sum[r]) << mrm_pkg::FRACTION_BITS_DEF)
                    / SCALED_W'(roi_count[r]);
        res.mean  = (quot > SCALED_W'(mrm_pkg::MEAN_MAX)) ? mrm_pkg::MEAN_MAX
                                                          : quot[mrm_pkg::MEAN_W-1:0];
        res.empty = 1'b0;
      end
      pending_means.push_back(res);
    end
    for (int r = 0; r < REGIONS; r++) begin
      roi_sum[r]   = '0;
      roi_count[r] = '0;
    end
  endfunction

  function automatic logic [mrm_pkg::PIXEL_W-1:0] random_pixel();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return mrm_pkg::PIXEL_W'($urandom());
  endfunction

  function automatic logic [mrm_pkg::MASK_W-1:0] random_mask();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '1;
    if (pick == 1) return '0;
    if (pick == 2) return mrm_pkg::MASK_W'(1) << $urandom_range(mrm_pkg::MASK_W - 1);
    return mrm_pkg::MASK_W'($urandom());
  endfunction

  task automatic send_pixel(logic [mrm_pkg::PIXEL_W-1:0] pixel,
                            logic [mrm_pkg::MASK_W-1:0] mask, logic last, logic fixed,
                            logic [mrm_pkg::MEAN_W-1:0] fixed_mean, logic fixed_empty);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    pix_if.valid            <= 1'b1;
    pix_if.pixel_value      <= pixel;
    pix_if.region_mask_bits <= mask;
    pix_if.last_pixel       <= last;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    accumulate_pixel(pixel, mask, last, fixed, fixed_mean, fixed_empty);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, mrm_pkg::cfg_reg_e reg_code,
                            logic [mrm_pkg::APB_DATA_W-1:0] wdata,
                            output logic [mrm_pkg::APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {reg_code, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_register(mrm_pkg::cfg_reg_e reg_code,
                                logic [mrm_pkg::APB_DATA_W-1:0] value,
                                logic [mrm_pkg::APB_DATA_W-1:0] field_mask);
    logic [mrm_pkg::APB_DATA_W-1:0] wdata;
    logic [mrm_pkg::APB_DATA_W-1:0] rdata;
    // unused upper bits carry noise
    wdata = (value & field_mask) | (mrm_pkg::APB_DATA_W'($urandom()) & ~field_mask);
    apb_access(1'b1, reg_code, wdata, rdata);
    apb_access(1'b0, reg_code, '0, rdata);
    if (rdata !== (value & field_mask))
      note_mismatch("register read-back", value & field_mask, rdata);
  endtask

  task automatic set_config(logic [mrm_pkg::REGIONS_W-1:0] regions, logic wide);
    drain_results();
    // a last pixel with no active region gives nothing to wait for
    repeat (REPORT_CYCLES) @(posedge clk_i);
    write_register(mrm_pkg::CFG_REGIONS, mrm_pkg::APB_DATA_W'(regions),
                   mrm_pkg::APB_DATA_W'({mrm_pkg::REGIONS_W{1'b1}}));
    write_register(mrm_pkg::CFG_WIDE, mrm_pkg::APB_DATA_W'(wide), mrm_pkg::APB_DATA_W'(1));
    regions_cfg = regions;
    wide_cfg    = wide;
  endtask

  initial begin
    mean_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      mean_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    roi_mean_t want;
    if (rst_ni && mean_if.valid && mean_if.ready) begin
      if (pending_means.size() == 0) begin
        if (mismatches < 10)
          $display("result transfer for region %0d with nothing pending", mean_if.region_index);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (mean_if.region_index !== want.region)
          note_mismatch("region_index", want.region, mean_if.region_index);
        if (mean_if.mean_value !== want.mean)
          note_mismatch("mean_value", want.mean, mean_if.mean_value);
        if (mean_if.region_empty !== want.empty)
          note_mismatch("region_empty", want.empty, mean_if.region_empty);
        if (mean_if.last_region !== want.last)
          note_mismatch("last_region", want.last, mean_if.last_region);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (mean_if.valid && mean_if.ready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** masked_roi_mean_intensity: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int left;
    int len;
    int frames;
    rst_ni                  = 1'b0;
    pix_if.valid            = 1'b0;
    pix_if.pixel_value      = '0;
    pix_if.region_mask_bits = '0;
    pix_if.last_pixel       = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    regions_cfg             = mrm_pkg::REGIONS_RESET;
    wide_cfg                = mrm_pkg::WIDE_RESET;
    frames                  = 0;
    for (int r = 0; r < REGIONS; r++) begin
      roi_sum[r]   = '0;
      roi_count[r] = '0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].regions != regions_cfg || directed_rows[i].wide != wide_cfg)
        set_config(directed_rows[i].regions, directed_rows[i].wide);
      send_pixel(directed_rows[i].pixel, directed_rows[i].mask, directed_rows[i].last,
                 directed_rows[i].fixed, directed_rows[i].mean, directed_rows[i].empty);
    end

    foreach (phases[p]) begin
      set_config(phases[p].regions, phases[p].wide);
      send_idle_pct = phases[p].idle_pct;
      stall_pct     = phases[p].stall_pct;
      left          = phases[p].items;
      while (left > 0) begin
        len = ($urandom_range(99) < 15) ? $urandom_range(48, 20) : $urandom_range(8, 1);
        if (len > left) len = left;
        for (int k = 0; k < len; k++)
          send_pixel(random_pixel(), random_mask(), k == len - 1, 1'b0, '0, 1'b0);
        left -= len;
        frames++;
        // after every fifth frame, hold the next frame back until the report has been read out
        if (frames % 5 == 0) drain_results();
      end
    end

    drain_results();
    repeat (REPORT_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** masked_roi_mean_intensity: PASSED **");
    end else begin
      $display("** masked_roi_mean_intensity: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mrm_pkg.sv
hw/rtl/mrm_stream_if.sv
hw/rtl/mrm_divider.sv
hw/rtl/mrm_datapath.sv
hw/rtl/mrm_ctrl.sv
hw/rtl/masked_roi_mean_intensity.sv
test/tb_top.sv
